@@ rtl/core/pip_pkg.sv @@
package pip_pkg;

  localparam int COORD_W = 16;
  localparam int COUNT_W = 4;
  localparam int IDX_W   = 4;
  localparam int WIDE_W  = 8;

  localparam logic [COUNT_W-1:0] MIN_VERTICES = 4'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef struct packed {
    logic             wr_en;
    logic             load_pt;
    logic             clear;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_idx;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ rtl/core/pip_ctrl.sv @@
module pip_ctrl #(
  parameter int MAX_VERTICES = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [pip_pkg::IDX_W-1:0]   vertex_index_i,
  input  logic [pip_pkg::COUNT_W-1:0] count_i,
  input  pip_pkg::status_t            status_i,
  output pip_pkg::cmd_t               cmd_o
);
  import pip_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [1:0]         drain_q, drain_d;
  logic               accept;
  logic               count_ok;
  logic               idx_ok;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign count_ok = (count_i >= MIN_VERTICES) &&
                    ({{(WIDE_W-COUNT_W){1'b0}}, count_i} <= WIDE_W'(MAX_VERTICES));
  assign idx_ok   = {{(WIDE_W-IDX_W){1'b0}}, vertex_index_i} < WIDE_W'(MAX_VERTICES);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    drain_d = drain_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.wr_en = accept && (op_i == OP_WRITE) && idx_ok;
        if (accept && (op_i == OP_TEST)) begin
          cmd_o.load_pt = 1'b1;
          cmd_o.clear   = 1'b1;
          step_d        = '0;
          state_d       = count_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (step_q == '0);
        // first read fetches the closing vertex
        cmd_o.rd_idx   = (step_q == '0) ? count_i - 1'b1 : step_q - 1'b1;
        if (step_q == count_i) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      drain_q <= drain_d;
    end
  end

endmodule

@@ rtl/core/pip_dp.sv @@
module pip_dp #(
  parameter int MAX_VERTICES = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pip_pkg::cmd_t                      cmd_i,
  output pip_pkg::status_t                   status_o,
  input  logic [pip_pkg::IDX_W-1:0]          vertex_index_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o
);
  import pip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int DIF_W = COORD_W + 1;
  localparam int PRD_W = 2 * DIF_W;

  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

  logic [WIDE_W-1:0] waddr_wide, raddr_wide;
  logic [AW-1:0]     waddr, raddr;

  logic signed [COORD_W-1:0] px_q, py_q;
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic                      v1_q, f1_q, v2_q, v3_q;
  logic signed [DIF_W-1:0]   pyd_q, xd_q, pxd_q, dy_q;
  logic                      dypos2_q, dypos3_q;
  logic signed [PRD_W-1:0]   lhs_q, rhs_q;
  logic                      parity_q;
  logic                      out_valid_q, inside_q;

  logic straddle, xcond, hit, left;

  assign waddr_wide = {{(WIDE_W-IDX_W){1'b0}}, vertex_index_i};
  assign raddr_wide = {{(WIDE_W-IDX_W){1'b0}}, cmd_i.rd_idx};
  assign waddr      = waddr_wide[AW-1:0];
  assign raddr      = raddr_wide[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_x[waddr] <= coord_x_i;
      mem_y[waddr] <= coord_y_i;
    end
    if (cmd_i.rd_en) begin
      cur_x_q <= mem_x[raddr];
      cur_y_q <= mem_y[raddr];
    end
  end

  // cur = vertex i, prev = vertex j
  assign straddle = ((cur_y_q < py_q) && (prev_y_q >= py_q)) ||
                    ((prev_y_q < py_q) && (cur_y_q >= py_q));
  assign xcond    = (cur_x_q <= px_q) || (prev_x_q <= px_q);
  assign hit      = v1_q && !f1_q && straddle && xcond;
  assign left     = dypos3_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (v1_q) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    pyd_q    <= DIF_W'(py_q) - DIF_W'(cur_y_q);
    xd_q     <= DIF_W'(prev_x_q) - DIF_W'(cur_x_q);
    pxd_q    <= DIF_W'(px_q) - DIF_W'(cur_x_q);
    dy_q     <= DIF_W'(prev_y_q) - DIF_W'(cur_y_q);
    dypos2_q <= prev_y_q > cur_y_q;
    lhs_q    <= pyd_q * xd_q;
    rhs_q    <= pxd_q * dy_q;
    dypos3_q <= dypos2_q;
    if (cmd_i.out_load) begin
      inside_q <= parity_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      f1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      f1_q <= cmd_i.rd_first;
      v2_q <= hit;
      v3_q <= v2_q;
      if (cmd_i.clear) begin
        parity_q <= 1'b0;
      end else if (v3_q && left) begin
        parity_q <= !parity_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign inside_res_o      = inside_q;

endmodule

@@ rtl/core/point_in_polygon_test_unit.sv @@
// Vertex write: the block takes the next transfer right after.
// Point test: result valid once the scan and drain finish and the output is free; next
//   transfer taken as the result shows; one vertex read per cycle, 3-stage edge pipeline.
// Test with fewer than 3 (or too many) vertices: scan skipped, result reports outside.
// Reset (async, active low) clears control and vertex_count; table is not cleared.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_wr_en_i,
  input  logic [pip_pkg::COUNT_W-1:0]        cfg_wr_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [pip_pkg::IDX_W-1:0]          vertex_index_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o
);
  import pip_pkg::*;

  logic [COUNT_W-1:0] count_q;
  cmd_t               cmd;
  status_t            status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_wr_en_i) begin
      count_q <= cfg_wr_data_i;
    end
  end

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .vertex_index_i(vertex_index_i),
    .count_i       (count_q),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  pip_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .vertex_index_i(vertex_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_o  (inside_res_o)
  );

`ifndef SYNTHESIS
  a_degenerate_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((count_q < MIN_VERTICES) ||
                    ({{(WIDE_W-COUNT_W){1'b0}}, count_q} > WIDE_W'(MAX_VERTICES)))
    |-> !inside_res_o)
    else $error("inside reported for a degenerate polygon");

  a_test_occupies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_TEST) |=> in_stall_o)
    else $error("test transfer did not start a scan");

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a scan");
`endif

endmodule
